FILE: sv/x11sef_pkg.sv
// Shared types and constants for the server stream event filter.
package x11sef_pkg;

	// Framing phase of the byte stream.
	typedef enum logic [1:0] {
		PH_SETUP_HDR  = 2'd0,
		PH_SETUP_BODY = 2'd1,
		PH_MSG_UNIT   = 2'd2,
		PH_MSG_BODY   = 2'd3
	} x11sef_phase_t;

	localparam logic [6:0] TYPE_MASK      = 7'h7f;
	localparam logic [6:0] TYPE_REPLY     = 7'd1;
	localparam logic [6:0] TYPE_LEAVE     = 7'd8;
	localparam logic [6:0] TYPE_FOCUS_OUT = 7'd10;
	localparam logic [6:0] TYPE_GENERIC   = 7'd35;

	localparam logic [4:0] SETUP_HDR_LAST = 5'd7;
	localparam logic [4:0] SETUP_LEN_FIRST = 5'd6;
	localparam logic [4:0] UNIT_LAST      = 5'd31;
	localparam logic [4:0] LEN_FIRST      = 5'd4;
	localparam logic [4:0] LEN_LAST       = 5'd7;

	localparam int unsigned REM_W = 34;

	// Per-item decision handed from the framer to the output stage.
	typedef struct packed {
		logic       emit;
		logic [6:0] msg_type;
		logic       eom;
	} x11sef_res_t;

	// Shifts one byte into the gathered length word in the selected order.
	function automatic logic [31:0] gather(input logic [31:0] lw, input logic [7:0] b,
		input logic msb_first);
		if (msb_first) begin
			return {lw[23:0], b};
		end else begin
			return {b, lw[31:8]};
		end
	endfunction

endpackage

FILE: sv/x11sef_framer.sv
// Message framer: tracks phase, position and lengths, decides emit and end flag.
module x11sef_framer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   process,
	input  logic [7:0]             byte_in,
	input  logic                   byte_order_msb,
	output x11sef_pkg::x11sef_res_t res
);
	import x11sef_pkg::*;

	x11sef_phase_t      phase_q, phase_n;
	logic [4:0]         pos_q, pos_n;
	logic [31:0]        lw_q, lw_n;
	logic [REM_W-1:0]   rem_q, rem_n;
	logic [6:0]         type_q, type_n;
	logic               drop_q, drop_n;

	logic [31:0]        lw_g;
	logic [15:0]        len16;
	logic [REM_W-1:0]   rem_dec;
	logic [6:0]         type_now;
	logic               drop_now;
	logic               has_body;

	// Shared datapath terms for the current byte.
	assign lw_g     = gather(lw_q, byte_in, byte_order_msb);
	assign len16    = byte_order_msb ? lw_g[15:0] : lw_g[31:16];
	assign rem_dec  = rem_q - REM_W'(1);
	assign type_now = (pos_q == 5'd0) ? (byte_in[6:0] & TYPE_MASK) : type_q;
	assign drop_now = (pos_q == 5'd0) ?
		((type_now == TYPE_FOCUS_OUT) || (type_now == TYPE_LEAVE)) : drop_q;
	assign has_body = ((type_now == TYPE_REPLY) || (type_now == TYPE_GENERIC)) &&
		(lw_q != 32'd0);

	// Next-state logic.
	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		lw_n    = lw_q;
		rem_n   = rem_q;
		type_n  = type_q;
		drop_n  = drop_q;
		case (phase_q)
			PH_SETUP_HDR: begin
				if (pos_q >= SETUP_LEN_FIRST) begin
					lw_n = lw_g;
				end
				if (pos_q == SETUP_HDR_LAST) begin
					pos_n = 5'd0;
					if (len16 == 16'd0) begin
						phase_n = PH_MSG_UNIT;
					end else begin
						rem_n   = {(REM_W-18)'(0), len16, 2'b00};
						phase_n = PH_SETUP_BODY;
					end
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			PH_MSG_UNIT: begin
				type_n = type_now;
				drop_n = drop_now;
				if ((pos_q >= LEN_FIRST) && (pos_q <= LEN_LAST)) begin
					lw_n = lw_g;
				end
				if (pos_q == UNIT_LAST) begin
					pos_n = 5'd0;
					if (has_body) begin
						rem_n   = {lw_q, 2'b00};
						phase_n = PH_MSG_BODY;
					end
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			PH_SETUP_BODY, PH_MSG_BODY: begin
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					phase_n = PH_MSG_UNIT;
				end
			end
			default: begin
				phase_n = PH_SETUP_HDR;
			end
		endcase
	end

	// Per-byte output decision.
	always_comb begin
		res.emit     = 1'b1;
		res.msg_type = type_q;
		res.eom      = 1'b0;
		case (phase_q)
			PH_SETUP_HDR: begin
				res.eom = (pos_q == SETUP_HDR_LAST) && (len16 == 16'd0);
			end
			PH_SETUP_BODY: begin
				res.eom = (rem_dec == '0);
			end
			PH_MSG_UNIT: begin
				res.emit     = !drop_now;
				res.msg_type = type_now;
				res.eom      = (pos_q == UNIT_LAST) && !has_body;
			end
			PH_MSG_BODY: begin
				res.emit = !drop_q;
				res.eom  = (rem_dec == '0);
			end
			default: begin
				res.emit = 1'b0;
			end
		endcase
	end

	// State registers advance once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SETUP_HDR;
			pos_q   <= 5'd0;
			lw_q    <= 32'd0;
			rem_q   <= '0;
			type_q  <= 7'd0;
			drop_q  <= 1'b0;
		end else if (process) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			lw_q    <= lw_n;
			rem_q   <= rem_n;
			type_q  <= type_n;
			drop_q  <= drop_n;
		end
	end

endmodule

FILE: sv/x11sef_out_stage.sv
// Result register that holds one forwarded item until the sink takes it.
module x11sef_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   process,
	input  logic [7:0]             byte_in,
	input  x11sef_pkg::x11sef_res_t res,
	output logic                   can_load,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_byte,
	output logic [6:0]             message_type,
	output logic                   end_of_message
);
	import x11sef_pkg::*;

	logic       valid_s2;
	logic [7:0] byte_s2;
	logic [6:0] type_s2;
	logic       eom_s2;

	// The register frees up when empty or when its item leaves this cycle.
	assign can_load = !valid_s2 || out_ready;

	// Valid bit of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= process && res.emit;
		end
	end

	// Payload of the result register.
	always_ff @(posedge clk) begin
		if (can_load && process && res.emit) begin
			byte_s2 <= byte_in;
			type_s2 <= res.msg_type;
			eom_s2  <= res.eom;
		end
	end

	assign out_valid      = valid_s2;
	assign out_byte       = byte_s2;
	assign message_type   = type_s2;
	assign end_of_message = eom_s2;

endmodule

FILE: sv/x11_server_stream_event_filter_top.sv
// Top level of the server stream event filter: input register, framer, result register.
// An accepted byte passes the input register and the framer into the result register.
// Throughput: one byte per cycle unless the sink stalls; framer state updates once per byte.
// Dropped messages produce no output item but are still taken in byte by byte.
// Reset (arst_n low) clears framing state to the setup header, byte order to LSB first,
// and empties both the input and result registers.
module x11_server_stream_event_filter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] stream_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [6:0] message_type,
	output logic       end_of_message
);
	import x11sef_pkg::*;

	logic        msb_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        can_load;
	logic        process;
	x11sef_res_t res;

	// Byte order register, writable at any time.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msb_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			msb_q <= cfg_data;
		end
	end

	// The held item is processed whenever the result register can take it.
	assign process  = valid_s1 && can_load;
	assign in_ready = !valid_s1 || can_load;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= stream_byte;
		end
	end

	x11sef_framer u_framer (
		.clk            (clk),
		.arst_n         (arst_n),
		.process        (process),
		.byte_in        (byte_s1),
		.byte_order_msb (msb_q),
		.res            (res)
	);

	x11sef_out_stage u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.process        (process),
		.byte_in        (byte_s1),
		.res            (res),
		.can_load       (can_load),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.message_type   (message_type),
		.end_of_message (end_of_message)
	);

endmodule

FILE: sv/x11sef_checker.sv
// Port-level checks for the server stream event filter, bound to its top level.
module x11sef_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [6:0] message_type
);
	import x11sef_pkg::*;

	// A stalled output item stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(message_type))
		else $error("output item changed while stalled");

	// With the result register empty the block always takes input.
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// Filtered message types never reach the output.
	a_no_drop_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (message_type != TYPE_LEAVE) && (message_type != TYPE_FOCUS_OUT))
		else $error("dropped message type was forwarded");

	// Configuration writes are never stalled.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind x11_server_stream_event_filter_top x11sef_checker u_x11sef_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.message_type (message_type)
);

FILE: verif/x11_server_stream_event_filter_top_test.sv
// Self-checking testbench for the server stream event filter: random byte stream, framing check.
`timescale 1ns / 100ps

module x11_server_stream_event_filter_top_test;
	import x11sef_pkg::*;

	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned BLOCK_BYTES   = 120;
	localparam int unsigned RANDOM_BLOCKS = 4;
	localparam int unsigned MAX_PRINTS    = 20;

	// One forwarded byte as the output port shows it.
	typedef struct packed {
		logic [7:0] data;
		logic [6:0] mtype;
		logic       last;
	} fwd_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] stream_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [6:0] message_type;
	logic       end_of_message;

	// Bytes waiting to be offered, and forwarded bytes still to arrive.
	logic [7:0] stream_backlog[$];
	fwd_byte_t  forwarded_due[$];

	// Tracked framer state and byte order register.
	x11sef_phase_t trk_phase = PH_SETUP_HDR;
	logic [4:0]    trk_pos = 5'd0;
	logic [31:0]   trk_len = 32'd0;
	logic [33:0]   trk_left = 34'd0;
	logic [6:0]    trk_type = 7'd0;
	logic          trk_drop = 1'b0;
	logic          trk_msb = 1'b0;

	int unsigned errors = 0;
	int unsigned n_in = 0;
	int unsigned n_out = 0;
	int unsigned n_dropped = 0;
	int unsigned n_cfg = 0;
	int unsigned quiet = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_stall = 0;
	int unsigned rx_hold_req = 0;
	int unsigned rx_hold_left = 0;
	logic        calm = 1'b0;

	x11_server_stream_event_filter_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.stream_byte   (stream_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.message_type  (message_type),
		.end_of_message(end_of_message)
	);

	initial forever #5 clk = ~clk;

	// Prints one line per mismatch, up to a cap, and counts all of them.
	task automatic flag_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTS) begin
			$display("mismatch %0d at %0t: %s", errors, $realtime, what);
		end
	endtask

	// Idle length for either side: mostly none, sometimes short, rarely long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 70) begin
			return 0;
		end else if (roll < 95) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(4, 24);
		end
	endfunction

	// Moves one length byte into the gathered word in the current byte order.
	function automatic logic [31:0] take_length_byte(input logic [31:0] word, input logic [7:0] b);
		return trk_msb ? {word[23:0], b} : {b, word[31:8]};
	endfunction

	// Advances the tracked framer by one accepted byte and records what must come out.
	function automatic void frame_stream_byte(input logic [7:0] b);
		logic        eom;
		logic [15:0] len16;
		logic [33:0] extra;
		eom = 1'b0;
		case (trk_phase)
			PH_SETUP_HDR: begin
				if (trk_pos >= SETUP_LEN_FIRST) begin
					trk_len = take_length_byte(trk_len, b);
				end
				if (trk_pos == SETUP_HDR_LAST) begin
					len16 = trk_msb ? trk_len[15:0] : trk_len[31:16];
					trk_pos = 5'd0;
					if (len16 == 16'd0) begin
						eom = 1'b1;
						trk_phase = PH_MSG_UNIT;
					end else begin
						trk_left = {16'd0, len16, 2'b00};
						trk_phase = PH_SETUP_BODY;
					end
				end else begin
					trk_pos = trk_pos + 5'd1;
				end
			end
			PH_MSG_UNIT: begin
				if (trk_pos == 5'd0) begin
					trk_type = b[6:0] & TYPE_MASK;
					trk_drop = (trk_type == TYPE_LEAVE || trk_type == TYPE_FOCUS_OUT);
				end
				if (trk_pos >= LEN_FIRST && trk_pos <= LEN_LAST) begin
					trk_len = take_length_byte(trk_len, b);
				end
				if (trk_pos == UNIT_LAST) begin
					extra = (trk_type == TYPE_REPLY || trk_type == TYPE_GENERIC) ?
						{trk_len, 2'b00} : 34'd0;
					trk_pos = 5'd0;
					if (extra == 34'd0) begin
						eom = 1'b1;
					end else begin
						trk_left = extra;
						trk_phase = PH_MSG_BODY;
					end
				end else begin
					trk_pos = trk_pos + 5'd1;
				end
			end
			default: begin
				trk_left = trk_left - 34'd1;
				if (trk_left == 34'd0) begin
					eom = 1'b1;
					trk_phase = PH_MSG_UNIT;
				end
			end
		endcase
		// The drop flag is only ever set by a message unit, so setup bytes always pass.
		if (trk_drop) begin
			n_dropped++;
		end else begin
			forwarded_due.push_back('{data: b, mtype: trk_type, last: eom});
		end
	endfunction

	// Random payload byte with the two extremes favored.
	function automatic logic [7:0] rand_byte();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			return 8'h00;
		end else if (roll == 1) begin
			return 8'hff;
		end else begin
			return 8'($urandom_range(0, 255));
		end
	endfunction

	function automatic void put_body(input int unsigned count);
		repeat (count) stream_backlog.push_back(rand_byte());
	endfunction

	// A 32-byte message unit with its length field laid out in the given order.
	function automatic void put_unit(input logic [7:0] first, input logic [31:0] len,
		input logic msb);
		stream_backlog.push_back(first);
		put_body(3);
		for (int i = 0; i < 4; i++) begin
			stream_backlog.push_back(msb ? len[31 - 8 * i -: 8] : len[8 * i +: 8]);
		end
		put_body(24);
	endfunction

	// A whole message; only the length-carrying types get extra bytes.
	function automatic void put_message(input logic [7:0] first, input logic [31:0] len,
		input logic msb);
		put_unit(first, len, msb);
		if ((first[6:0] & TYPE_MASK) == TYPE_REPLY || (first[6:0] & TYPE_MASK) == TYPE_GENERIC) begin
			put_body(4 * len);
		end
	endfunction

	// Every type class; filtered and length-carrying types both with and without the high bit.
	function automatic void put_directed_messages(input logic msb);
		put_message({1'b1, 7'd0}, $urandom(), msb);
		put_message({1'b1, TYPE_MASK}, $urandom(), msb);
		put_message({1'b0, TYPE_LEAVE}, $urandom(), msb);
		put_message({1'b1, TYPE_LEAVE}, $urandom(), msb);
		put_message({1'b0, TYPE_FOCUS_OUT}, $urandom(), msb);
		put_message({1'b1, TYPE_FOCUS_OUT}, $urandom(), msb);
		put_message({1'b0, TYPE_REPLY}, 32'd0, msb);
		put_message({1'b0, TYPE_REPLY}, 32'd1, msb);
		put_message({1'b1, TYPE_REPLY}, 32'd2, msb);
		put_message({1'b0, TYPE_GENERIC}, 32'd0, msb);
		put_message({1'b0, TYPE_GENERIC}, 32'd3, msb);
		put_message({1'b1, TYPE_GENERIC}, 32'd1, msb);
		put_message({1'b0, TYPE_LEAVE + 7'd1}, $urandom(), msb);
		put_message({1'b0, TYPE_FOCUS_OUT + 7'd1}, $urandom(), msb);
		put_message({1'b0, TYPE_GENERIC + 7'd1}, $urandom(), msb);
	endfunction

	// Mostly well-formed messages with random content, plus some junk units.
	function automatic void put_random_message(input logic msb);
		int unsigned roll;
		int unsigned count;
		logic [6:0]  t;
		logic [7:0]  b;
		logic [31:0] len;
		logic        hi;
		roll = $urandom_range(0, 99);
		hi = 1'($urandom_range(0, 1));
		if (roll < 35) begin
			t = $urandom_range(0, 1) ? TYPE_REPLY : TYPE_GENERIC;
			len = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 4) : $urandom_range(5, 24);
		end else if (roll < 50) begin
			t = $urandom_range(0, 1) ? TYPE_LEAVE : TYPE_FOCUS_OUT;
			len = $urandom();
		end else if (roll < 60) begin
			// Junk padded to a unit boundary; no length-carrying type can start in it.
			count = $urandom_range(1, 40);
			count = count + (32 - count % 32) % 32;
			repeat (count) begin
				do begin
					b = 8'($urandom_range(0, 255));
				end while (b[6:0] == TYPE_REPLY || b[6:0] == TYPE_GENERIC);
				stream_backlog.push_back(b);
			end
			return;
		end else begin
			do begin
				t = 7'($urandom_range(0, 127));
			end while (t == TYPE_REPLY || t == TYPE_GENERIC || t == TYPE_LEAVE ||
				t == TYPE_FOCUS_OUT);
			len = $urandom();
		end
		put_message({hi, t}, len, msb);
	endfunction

	// Writes the byte order register; only called while nothing is in flight.
	task automatic set_byte_order(input logic msb);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= msb;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		trk_msb = msb;
		n_cfg++;
	endtask

	// Waits until the backlog is sent and every forwarded byte is in, then lets the pipe settle.
	task automatic wait_drained();
		do @(negedge clk); while (stream_backlog.size() != 0 || in_valid ||
			forwarded_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Length field read across a byte order change: the prefix unit clears the gathered word.
	task automatic put_split_length(input logic first_msb);
		logic [7:0] tail;
		set_byte_order(first_msb);
		@(negedge clk);
		put_message({1'b0, TYPE_FOCUS_OUT}, 32'd0, first_msb);
		stream_backlog.push_back({1'b1, TYPE_GENERIC});
		put_body(5);
		wait_drained();
		set_byte_order(!first_msb);
		@(negedge clk);
		// Starting most significant first, zero tail bytes leave a zero length;
		// the other way round the last byte alone becomes the length.
		tail = first_msb ? 8'd0 : 8'($urandom_range(1, 6));
		stream_backlog.push_back(8'd0);
		stream_backlog.push_back(tail);
		put_body(24 + 4 * tail);
		wait_drained();
	endtask

	// Sender: offers the backlog in order, with random gaps between items.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			frame_stream_byte(stream_byte);
			void'(stream_backlog.pop_front());
			n_in++;
			tx_gap = pick_gap();
		end
		if (in_valid && !in_ready) begin
			// Item still pending: keep valid and payload as they are.
		end else if (tx_gap != 0) begin
			tx_gap--;
			in_valid <= 1'b0;
		end else if (stream_backlog.size() != 0) begin
			in_valid <= 1'b1;
			stream_byte <= stream_backlog[0];
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: checks each forwarded byte and stalls at random or for one long stretch.
	always @(posedge clk) begin : rx_side
		fwd_byte_t due;
		if (out_valid && out_ready) begin
			n_out++;
			if (forwarded_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected byte %02h type %0d", out_byte, message_type));
			end else begin
				due = forwarded_due.pop_front();
				if (out_byte !== due.data) begin
					flag_mismatch($sformatf("out_byte %02h, wanted %02h", out_byte, due.data));
				end
				if (message_type !== due.mtype) begin
					flag_mismatch($sformatf("message_type %0d, wanted %0d", message_type,
						due.mtype));
				end
				if (end_of_message !== due.last) begin
					flag_mismatch($sformatf("end_of_message %b, wanted %b on byte %02h",
						end_of_message, due.last, due.data));
				end
			end
		end
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (rx_stall != 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			rx_stall = pick_gap();
		end
	end

	// Watchdog: ends the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet == QUIET_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles, %0d bytes still due.", quiet,
				forwarded_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Test sequence.
	initial begin : sequencer
		logic        order;
		logic [15:0] setup_len;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Setup reply, then the directed messages of every class; the random blocks use both orders.
		order = 1'($urandom_range(0, 1));
		set_byte_order(order);
		@(negedge clk);
		setup_len = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 6));
		put_body(6);
		stream_backlog.push_back(order ? setup_len[15:8] : setup_len[7:0]);
		stream_backlog.push_back(order ? setup_len[7:0] : setup_len[15:8]);
		put_body(4 * setup_len);
		put_directed_messages(order);
		wait_drained();

		// Byte order flipped in the middle of a length field, both ways.
		put_split_length(1'b0);
		put_split_length(1'b1);

		// Random blocks: one without any idling, one with a long receiver hold.
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			order = blk[0];
			set_byte_order(order);
			@(negedge clk);
			calm = (blk == 1);
			while (stream_backlog.size() < BLOCK_BYTES) put_random_message(order);
			if (blk == 3) begin
				rx_hold_req = HOLD_CYCLES;
			end
			wait_drained();
			calm = 1'b0;
		end

		// Largest possible length: the stream stops partway into the extra bytes.
		order = 1'($urandom_range(0, 1));
		set_byte_order(order);
		@(negedge clk);
		put_unit({1'b0, TYPE_GENERIC}, 32'hffff_ffff, order);
		put_body(40);
		wait_drained();

		$display("Run covered %0d stream bytes in, %0d forwarded, %0d filtered with dropped events.",
			n_in, n_out, n_dropped);
		$display("Byte order written %0d times, including changes inside a length field.", n_cfg);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: x11_server_stream_event_filter_top.f
sv/x11sef_pkg.sv
sv/x11sef_framer.sv
sv/x11sef_out_stage.sv
sv/x11_server_stream_event_filter_top.sv
sv/x11sef_checker.sv
verif/x11_server_stream_event_filter_top_test.sv
